[hw/rtl/srp_pkg.sv]
// Shared types and constants for the shelf rectangle packer.
`timescale 1ns / 1ps
package srp_pkg;

    localparam int MAX_RECTS = 32;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;
    localparam int DIM_BITS  = 14;
    localparam int ID_W      = 16;
    localparam int TOP_W     = 20;
    localparam int EXT_W     = 17;
    localparam int GAP_W     = 8;
    localparam int MAXW_W    = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 120;

    // Register indexes on the configuration port
    localparam logic REG_GAP  = 1'b0;
    localparam logic REG_MAXW = 1'b1;

    // Result kinds
    localparam logic KIND_PLACE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEL_RD,
        ST_SEL_CHK,
        ST_SH_RD,
        ST_SH_CHK,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
    } rect_t;

    typedef struct packed {
        logic [TOP_W-1:0]    top;
        logic [EXT_W-1:0]    ext;
        logic [DIM_BITS-1:0] tall;
    } shelf_t;

endpackage

[hw/rtl/shelf_rect_packer_unit.sv]
// Shelf packer: loads rectangles, orders them by height, places them on shelves.
// Loading: one rectangle word per cycle, ready whenever the unit is loading.
// Packing N stored words: N+1 selection passes over the store, then per placed rectangle
// a first-fit read of the shelves; placement and summary words can stall on the output.
// The output register lets the next run load while the summary waits.
// rst_n clears control state, restores gap 0 and maximum width 1024; memories not reset.
`timescale 1ns / 1ps
module shelf_rect_packer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // rectangle words in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [srp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // rect_id, rect_width, rect_height
    input  logic                              s_axis_tlast,  // last_rect
    // result words out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // place_id, place_x, place_y, place_width, place_height, sheet_width,
    // sheet_height, overflow_flag
    output logic [srp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,  // result_kind
    output logic                              m_axis_tlast   // last_result
);
    import srp_pkg::*;

    state_t state_reg, state_next;
    logic [GAP_W-1:0]  gap_reg;
    logic [MAXW_W-1:0] maxw_reg;
    logic [CNT_W-1:0]  rect_cnt_reg, rect_cnt_next;
    logic [CNT_W-1:0]  shelf_cnt_reg, shelf_cnt_next;
    logic              dropped_reg, dropped_next;
    logic [MAX_RECTS-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              best_found_reg, best_found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    rect_t             best_reg, best_next;
    logic [TOP_W-1:0]  bottom_reg, bottom_next;
    logic [EXT_W-1:0]  max_ext_reg, max_ext_next;
    logic [TOP_W-1:0]  max_bot_reg, max_bot_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // memories
    rect_t  rect_mem [MAX_RECTS];
    shelf_t shelf_mem [MAX_RECTS];
    rect_t  rect_q_reg;
    shelf_t shelf_q_reg;
    logic             rect_we, rect_re, shelf_we, shelf_re;
    logic [IDX_W-1:0] rect_waddr, rect_raddr, shelf_waddr, shelf_raddr;
    rect_t            rect_wdata;
    shelf_t           shelf_wdata;

    // arithmetic
    logic [MAXW_W-1:0]   maxw_eff;
    logic [DIM_BITS:0]   rwg;
    logic [EXT_W:0]      sum_ext;
    logic                fits;
    logic [DIM_BITS-1:0] new_tall;
    logic [TOP_W-1:0]    bot_cand;
    logic [TOP_W-1:0]    place_bot;
    logic                better;
    logic                out_free;
    logic [EXT_W-1:0]    sheet_w;

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg  <= '0;
            maxw_reg <= MAXW_W'(1024);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_GAP:  gap_reg  <= pwdata[GAP_W-1:0];
                REG_MAXW: maxw_reg <= pwdata[MAXW_W-1:0];
                default:  gap_reg  <= gap_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_GAP:  prdata = {24'd0, gap_reg};
            REG_MAXW: prdata = {16'd0, maxw_reg};
            default:  prdata = '0;
        endcase
    end

    // rectangle store
    always_ff @(posedge clk)
    begin
        if (rect_we)
            rect_mem[rect_waddr] <= rect_wdata;
        if (rect_re)
            rect_q_reg <= rect_mem[rect_raddr];
    end

    // shelf store
    always_ff @(posedge clk)
    begin
        if (shelf_we)
            shelf_mem[shelf_waddr] <= shelf_wdata;
        if (shelf_re)
            shelf_q_reg <= shelf_mem[shelf_raddr];
    end

    // datapath terms
    assign maxw_eff = (maxw_reg == '0) ? MAXW_W'(1) : maxw_reg;
    assign rwg      = {1'b0, best_reg.w} + (DIM_BITS+1)'(gap_reg);
    assign sum_ext  = {1'b0, shelf_q_reg.ext} + (EXT_W+1)'(rwg);
    assign fits     = sum_ext <= (EXT_W+1)'(maxw_eff);
    assign new_tall = (best_reg.h > shelf_q_reg.tall) ? best_reg.h : shelf_q_reg.tall;
    assign bot_cand = shelf_q_reg.top + TOP_W'(shelf_q_reg.tall) + TOP_W'(gap_reg);
    assign place_bot = shelf_q_reg.top + TOP_W'(new_tall);
    assign better   = !best_found_reg || (rect_q_reg.h > best_reg.h)
                   || ((rect_q_reg.h == best_reg.h) && (rect_q_reg.id < best_reg.id));
    assign out_free = !out_valid_reg || m_axis_tready;
    assign sheet_w  = (max_ext_reg > EXT_W'(gap_reg)) ? max_ext_reg - EXT_W'(gap_reg) : '0;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // control and next state
    always_comb
    begin
        state_next      = state_reg;
        rect_cnt_next   = rect_cnt_reg;
        shelf_cnt_next  = shelf_cnt_reg;
        dropped_next    = dropped_reg;
        taken_next      = taken_reg;
        scan_next       = scan_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        bottom_next     = bottom_reg;
        max_ext_next    = max_ext_reg;
        max_bot_next    = max_bot_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        out_data_next   = out_data_reg;
        rect_we     = 1'b0;
        rect_waddr  = rect_cnt_reg[IDX_W-1:0];
        rect_wdata  = rect_t'(s_axis_tdata[43:0]);
        rect_re     = 1'b0;
        rect_raddr  = scan_reg[IDX_W-1:0];
        shelf_we    = 1'b0;
        shelf_waddr = scan_reg[IDX_W-1:0];
        shelf_wdata = '0;
        shelf_re    = 1'b0;
        shelf_raddr = scan_reg[IDX_W-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    if (rect_cnt_reg < CNT_W'(MAX_RECTS))
                    begin
                        rect_we       = 1'b1;
                        rect_wdata.id = s_axis_tdata[15:0];
                        rect_wdata.w  = s_axis_tdata[29:16];
                        rect_wdata.h  = s_axis_tdata[43:30];
                        rect_cnt_next = rect_cnt_reg + CNT_W'(1);
                    end
                    else
                        dropped_next = 1'b1;
                    if (s_axis_tlast)
                    begin
                        taken_next      = '0;
                        scan_next       = '0;
                        best_found_next = 1'b0;
                        shelf_cnt_next  = '0;
                        max_ext_next    = '0;
                        max_bot_next    = '0;
                        state_next      = ST_SEL_RD;
                    end
                end
            end
            // one selection pass picks the next rectangle in packing order
            ST_SEL_RD:
            begin
                if (scan_reg < rect_cnt_reg)
                begin
                    rect_re    = 1'b1;
                    state_next = ST_SEL_CHK;
                end
                else if (best_found_reg)
                begin
                    taken_next[best_idx_reg] = 1'b1;
                    scan_next       = '0;
                    best_found_next = 1'b0;
                    bottom_next     = '0;
                    if (best_reg.w == '0 || best_reg.h == '0)
                        state_next = ST_SEL_RD;
                    else
                        state_next = ST_SH_RD;
                end
                else
                    state_next = ST_SUMMARY;
            end
            ST_SEL_CHK:
            begin
                if (!taken_reg[scan_reg[IDX_W-1:0]] && better)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = scan_reg[IDX_W-1:0];
                    best_next       = rect_q_reg;
                end
                scan_next  = scan_reg + CNT_W'(1);
                state_next = ST_SEL_RD;
            end
            // first-fit shelf search for the chosen rectangle
            ST_SH_RD:
            begin
                if (scan_reg < shelf_cnt_reg)
                begin
                    shelf_re   = 1'b1;
                    state_next = ST_SH_CHK;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PLACE;
                    out_last_next  = 1'b0;
                    out_data_next  = '0;
                    out_data_next[15:0]  = best_reg.id;
                    out_data_next[65:52] = best_reg.w;
                    out_data_next[79:66] = best_reg.h;
                    if (shelf_cnt_reg < CNT_W'(MAX_RECTS))
                    begin
                        shelf_we          = 1'b1;
                        shelf_waddr       = shelf_cnt_reg[IDX_W-1:0];
                        shelf_wdata.top   = bottom_reg;
                        shelf_wdata.ext   = EXT_W'(rwg);
                        shelf_wdata.tall  = best_reg.h;
                        shelf_cnt_next    = shelf_cnt_reg + CNT_W'(1);
                        out_data_next[51:32] = bottom_reg;
                        if (EXT_W'(rwg) > max_ext_reg)
                            max_ext_next = EXT_W'(rwg);
                        if (bottom_reg + TOP_W'(best_reg.h) > max_bot_reg)
                            max_bot_next = bottom_reg + TOP_W'(best_reg.h);
                    end
                    scan_next  = '0;
                    state_next = ST_SEL_RD;
                end
            end
            ST_SH_CHK:
            begin
                if (fits)
                begin
                    if (out_free)
                    begin
                        shelf_we         = 1'b1;
                        shelf_wdata.top  = shelf_q_reg.top;
                        shelf_wdata.ext  = sum_ext[EXT_W-1:0];
                        shelf_wdata.tall = new_tall;
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_PLACE;
                        out_last_next  = 1'b0;
                        out_data_next  = '0;
                        out_data_next[15:0]  = best_reg.id;
                        out_data_next[31:16] = shelf_q_reg.ext[15:0];
                        out_data_next[51:32] = shelf_q_reg.top;
                        out_data_next[65:52] = best_reg.w;
                        out_data_next[79:66] = best_reg.h;
                        if (sum_ext[EXT_W-1:0] > max_ext_reg)
                            max_ext_next = sum_ext[EXT_W-1:0];
                        if (place_bot > max_bot_reg)
                            max_bot_next = place_bot;
                        scan_next  = '0;
                        state_next = ST_SEL_RD;
                    end
                end
                else
                begin
                    if (bot_cand > bottom_reg)
                        bottom_next = bot_cand;
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = ST_SH_RD;
                end
            end
            ST_SUMMARY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_SUMMARY;
                    out_last_next  = 1'b1;
                    out_data_next  = '0;
                    out_data_next[95:80]  = sheet_w[15:0];
                    out_data_next[115:96] = max_bot_reg;
                    out_data_next[116]    = dropped_reg;
                    rect_cnt_next  = '0;
                    shelf_cnt_next = '0;
                    dropped_next   = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            rect_cnt_reg   <= '0;
            shelf_cnt_reg  <= '0;
            dropped_reg    <= 1'b0;
            taken_reg      <= '0;
            scan_reg       <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_reg       <= '0;
            bottom_reg     <= '0;
            max_ext_reg    <= '0;
            max_bot_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rect_cnt_reg   <= rect_cnt_next;
            shelf_cnt_reg  <= shelf_cnt_next;
            dropped_reg    <= dropped_next;
            taken_reg      <= taken_next;
            scan_reg       <= scan_next;
            best_found_reg <= best_found_next;
            best_idx_reg   <= best_idx_next;
            best_reg       <= best_next;
            bottom_reg     <= bottom_next;
            max_ext_reg    <= max_ext_next;
            max_bot_reg    <= max_bot_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_last_reg   <= out_last_next;
            out_data_reg   <= out_data_next;
        end
    end

    // checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rect_cnt_reg <= CNT_W'(MAX_RECTS))
        else $error("rectangle count beyond capacity");
    a_shelf_le_rect: assert property (@(posedge clk) disable iff (!rst_n)
        shelf_cnt_reg <= rect_cnt_reg)
        else $error("more shelves than rectangles");
    a_load_no_shelves: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> shelf_cnt_reg == '0)
        else $error("shelves left over while loading");
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_kind_reg == out_last_reg))
        else $error("summary and last marker disagree");
endmodule

[verif/shelf_rect_packer_unit_tb.sv]
// Testbench for the shelf rectangle packer: stream stimulus, APB setup, scoreboard checks.
`timescale 1ns / 1ps
module shelf_rect_packer_unit_tb;
    import srp_pkg::*;

    typedef struct {
        logic        kind;
        logic [15:0] id;
        logic [15:0] x;
        logic [19:0] y;
        logic [13:0] w;
        logic [13:0] h;
        logic [15:0] sw;
        logic [19:0] sh;
        logic        ovf;
        logic        last;
    } placement_t;

    // Packing predictor and queue of expected placements
    class packing_board;
        int unsigned gap;
        int unsigned maxw;
        int unsigned ids[$];
        int unsigned wds[$];
        int unsigned hts[$];
        bit          dropped;
        placement_t  pending[$];
        int          errors;

        function new();
            gap = 0;
            maxw = 1024;
            dropped = 0;
            errors = 0;
        endfunction

        function void note_rect(logic [15:0] id, logic [13:0] w, logic [13:0] h, logic lst);
            int unsigned stop[$];
            int unsigned sext[$];
            int unsigned stall[$];
            int unsigned order[$];
            int unsigned mw;
            int unsigned rwg;
            int unsigned bot;
            int unsigned mext;
            int unsigned mbot;
            int          j;
            int          k;
            bit          done;
            placement_t  p;
            if (ids.size() < MAX_RECTS)
            begin
                ids = {ids, id};
                wds = {wds, w};
                hts = {hts, h};
            end
            else
                dropped = 1;
            if (!lst)
                return;
            mw = (maxw == 0) ? 1 : maxw;
            // stable insertion order: height down, id up
            for (int i = 0; i < ids.size(); i++)
            begin
                j = order.size();
                while (j > 0 && (hts[i] > hts[order[j-1]] ||
                       (hts[i] == hts[order[j-1]] && ids[i] < ids[order[j-1]])))
                    j--;
                order.insert(j, i);
            end
            foreach (order[n])
            begin
                k = order[n];
                if (wds[k] == 0 || hts[k] == 0)
                    continue;
                rwg = wds[k] + gap;
                done = 0;
                p = '{default: 0};
                p.kind = KIND_PLACE;
                p.id = ids[k];
                p.w = wds[k];
                p.h = hts[k];
                for (int s = 0; s < stop.size() && !done; s++)
                    if (sext[s] + rwg <= mw)
                    begin
                        p.x = sext[s];
                        p.y = stop[s];
                        sext[s] += rwg;
                        if (hts[k] > stall[s])
                            stall[s] = hts[k];
                        done = 1;
                    end
                if (!done)
                begin
                    bot = 0;
                    foreach (stop[s])
                        if (stop[s] + stall[s] + gap > bot)
                            bot = stop[s] + stall[s] + gap;
                    stop = {stop, bot};
                    sext = {sext, rwg};
                    stall = {stall, hts[k]};
                    p.x = 0;
                    p.y = bot;
                end
                pending = {pending, p};
            end
            mext = 0;
            mbot = 0;
            foreach (stop[s])
            begin
                if (sext[s] > mext)
                    mext = sext[s];
                if (stop[s] + stall[s] > mbot)
                    mbot = stop[s] + stall[s];
            end
            p = '{default: 0};
            p.kind = KIND_SUMMARY;
            p.sw = (mext > gap) ? mext - gap : 0;
            p.sh = mbot;
            p.ovf = dropped;
            p.last = 1;
            pending = {pending, p};
            ids.delete();
            wds.delete();
            hts.delete();
            dropped = 0;
        endfunction

        function void check_result(placement_t a);
            placement_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result word kind=%0d id=%0d", a.kind, a.id);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind) begin $error("result_kind exp %0d got %0d", e.kind, a.kind); errors++; end
            if (a.id !== e.id) begin $error("place_id exp %0d got %0d", e.id, a.id); errors++; end
            if (a.x !== e.x) begin $error("place_x exp %0d got %0d", e.x, a.x); errors++; end
            if (a.y !== e.y) begin $error("place_y exp %0d got %0d", e.y, a.y); errors++; end
            if (a.w !== e.w) begin $error("place_width exp %0d got %0d", e.w, a.w); errors++; end
            if (a.h !== e.h) begin $error("place_height exp %0d got %0d", e.h, a.h); errors++; end
            if (a.sw !== e.sw) begin $error("sheet_width exp %0d got %0d", e.sw, a.sw); errors++; end
            if (a.sh !== e.sh) begin $error("sheet_height exp %0d got %0d", e.sh, a.sh); errors++; end
            if (a.ovf !== e.ovf) begin $error("overflow_flag exp %0d got %0d", e.ovf, a.ovf); errors++; end
            if (a.last !== e.last) begin $error("last_result exp %0d got %0d", e.last, a.last); errors++; end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    packing_board board;
    int  send_idle;   // percent of cycles the sender idles
    int  recv_stall;  // percent of cycles the receiver stalls
    int  hold_off;    // cycles of forced receiver hold-off
    longint cycles;

    shelf_rect_packer_unit uut (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: ready pattern and hold-off
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Result capture
    always @(posedge clk)
    begin
        placement_t a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            {a.ovf, a.sh, a.sw, a.h, a.w, a.y, a.x, a.id} = m_axis_tdata[116:0];
            a.kind = m_axis_tuser;
            a.last = m_axis_tlast;
            board.check_result(a);
        end
    end

    task automatic apb_write(logic idx, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == REG_GAP)
            board.gap = val[7:0];
        else
            board.maxw = val[15:0];
    endtask

    // Called at a falling edge; leaves tvalid high so words can follow back to back
    task automatic send_rect(logic [15:0] id, logic [13:0] w, logic [13:0] h, logic lst);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {4'd0, h, w, id};
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_rect(id, w, h, lst);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    // Random set: mostly small dimensions, some extremes
    task automatic random_set(int n);
        logic [13:0] w;
        logic [13:0] h;
        for (int i = 0; i < n; i++)
        begin
            w = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(300));
            h = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(8) * 16);
            send_rect(16'($urandom), w, h, i == n - 1);
        end
    endtask

    initial
    begin
        int sent;
        int n;
        board = new();
        cycles = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        m_axis_tready = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: defaults, ties, zero sizes, wide rectangle
        send_rect(16'hFFFF, 14'h3FFF, 14'h3FFF, 0);
        send_rect(16'd5, 14'd100, 14'd50, 0);
        send_rect(16'd3, 14'd100, 14'd50, 0);
        send_rect(16'd3, 14'd200, 14'd50, 0);
        send_rect(16'd7, 14'd0, 14'd40, 0);
        send_rect(16'd8, 14'd40, 14'd0, 0);
        send_rect(16'd0, 14'd1, 14'd1, 1);
        drain();
        // Only skipped rectangles: empty sheet
        send_rect(16'd1, 14'd0, 14'd0, 1);
        drain();
        // Extremes of registers: zero width treated as one, big gap
        apb_write(REG_GAP, 32'd255);
        apb_write(REG_MAXW, 32'd0);
        send_rect(16'd2, 14'd1, 14'd9, 0);
        send_rect(16'd4, 14'd1, 14'd9, 1);
        drain();
        apb_write(REG_GAP, 32'd3);
        apb_write(REG_MAXW, 32'd65535);
        // Capacity overflow with last dropped
        for (int i = 0; i < 34; i++)
            send_rect(16'(i * 3), 14'($urandom_range(1, 2000)), 14'($urandom_range(1, 50)),
                      i == 33);
        drain();

        // Random phases with varied idling and settings
        sent = 0;
        for (int ph = 0; sent < 66; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 66; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 66; end
                default: begin send_idle = 36; recv_stall = 36; end
            endcase
            apb_write(REG_GAP, $urandom_range(0, 1) ? 32'($urandom_range(255)) : 32'd0);
            apb_write(REG_MAXW, 32'($urandom_range(1, 1200)));
            if (ph == 2)
            begin
                // long hold-off while the next set streams in behind the summary
                hold_off = 3000;
                random_set(6);
                random_set(5);
                sent += 11;
            end
            else
            begin
                n = $urandom_range(1, 12);
                random_set(n);
                sent += n;
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
